@@ sv/dws_pkg.sv @@
package dws_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int FUNC_W       = 3;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SEARCH     = 3'd4,
        FN_READOUT    = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

@@ sv/dws_ram.sv @@
module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/deque_with_search.sv @@
// Channel | Direction | Ports                                        | Handshake
// input   | in        | s_func, s_value                              | s_valid / s_ready
// result  | out       | m_status, m_position, m_data, m_last         | m_valid / m_ready
//
// Push, pop and unused codes give their beat in the next cycle.
// Search and read-out step the element memory one entry per cycle, while the result
// channel is free, through its registered read port.
// Reset (aresetn low, synchronous) empties the list; the memory is not cleared.
// A stalled result beat holds the scan and blocks new input beats.
module deque_with_search #(
    parameter int CAPACITY = dws_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [dws_pkg::FUNC_W-1:0]     s_func,
    input  logic signed [dws_pkg::VALUE_W-1:0] s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dws_pkg::STATUS_W-1:0]   m_status,
    output logic [dws_pkg::POS_W-1:0]      m_position,
    output logic signed [dws_pkg::VALUE_W-1:0] m_data,
    output logic                           m_last
);
    import dws_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = IW + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
        ptr_inc = (p == IW'(CAPACITY - 1)) ? '0 : p + IW'(1);
    endfunction

    function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
        ptr_dec = (p == '0) ? IW'(CAPACITY - 1) : p - IW'(1);
    endfunction

    state_t              state_reg, state_next;
    logic [IW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                search_reg, search_next;
    logic [VALUE_W-1:0]  key_reg, key_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic [IW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                pv_reg, pv_next;
    logic [IW-1:0]       pidx_reg, pidx_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [POS_W-1:0]    m_position_reg;
    logic [VALUE_W-1:0]  m_data_reg;
    logic                m_last_reg;

    logic                out_free;
    logic                accept;
    logic                ld;
    status_t             ld_status;
    logic [POS_W-1:0]    ld_pos;
    logic [VALUE_W-1:0]  ld_data;
    logic                ld_last;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic                ram_re;
    logic [VALUE_W-1:0]  ram_rdata;

    logic [SW-1:0]       back_sum;
    logic [IW-1:0]       back_ptr;
    logic                pidx_last;
    logic                done;
    logic                full;
    logic                empty;

    dws_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_value),
        .re   (ram_re),
        .raddr(rd_ptr_reg),
        .rdata(ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_ptr  = (back_sum >= SW'(CAPACITY)) ? IW'(back_sum - SW'(CAPACITY))
                                                   : IW'(back_sum);
    assign pidx_last = ((CW'(pidx_reg) + CW'(1)) == count_reg);

    always_comb begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        search_next = search_reg;
        key_next    = key_reg;
        rd_idx_next = rd_idx_reg;
        rd_ptr_next = rd_ptr_reg;
        pv_next     = pv_reg;
        pidx_next   = pidx_reg;
        ram_we      = 1'b0;
        ram_waddr   = back_ptr;
        ram_re      = 1'b0;
        ld          = 1'b0;
        ld_status   = ST_OK;
        ld_pos      = '0;
        ld_data     = '0;
        ld_last     = 1'b1;
        done        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ld = 1'b1;
                    case (func_t'(s_func))
                        FN_PUSH_FRONT: begin
                            if (full) begin
                                ld_status = ST_FULL;
                            end else begin
                                front_next = ptr_dec(front_reg);
                                ram_we     = 1'b1;
                                ram_waddr  = ptr_dec(front_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_PUSH_BACK: begin
                            if (full) begin
                                ld_status = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_POP_FRONT: begin
                            if (empty) begin
                                ld_status = ST_EMPTY;
                            end else begin
                                front_next = ptr_inc(front_reg);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        FN_POP_BACK: begin
                            if (empty) begin
                                ld_status = ST_EMPTY;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        FN_SEARCH, FN_READOUT: begin
                            if (empty) begin
                                ld_status = (s_func == FN_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
                            end else begin
                                ld          = 1'b0;
                                state_next  = S_SCAN;
                                search_next = (s_func == FN_SEARCH);
                                key_next    = s_value;
                                rd_idx_next = '0;
                                rd_ptr_next = front_reg;
                                pv_next     = 1'b0;
                            end
                        end
                        default: begin
                            ld_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    if (pv_reg) begin
                        if (search_reg) begin
                            if (ram_rdata == key_reg) begin
                                ld     = 1'b1;
                                ld_pos = POS_W'(CW'(pidx_reg) + CW'(1));
                                done   = 1'b1;
                            end else if (pidx_last) begin
                                ld        = 1'b1;
                                ld_status = ST_NOT_FOUND;
                                done      = 1'b1;
                            end
                        end else begin
                            ld      = 1'b1;
                            ld_data = ram_rdata;
                            ld_last = pidx_last;
                            done    = pidx_last;
                        end
                    end
                    if (done) begin
                        state_next = S_IDLE;
                        pv_next    = 1'b0;
                    end else if (rd_idx_reg < count_reg) begin
                        ram_re      = 1'b1;
                        pv_next     = 1'b1;
                        pidx_next   = rd_idx_reg[IW-1:0];
                        rd_idx_next = rd_idx_reg + CW'(1);
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                    end else begin
                        pv_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = ld ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        search_reg <= search_next;
        key_reg    <= key_next;
        rd_idx_reg <= rd_idx_next;
        rd_ptr_reg <= rd_ptr_next;
        pidx_reg   <= pidx_next;
        if (ld) begin
            m_status_reg   <= ld_status;
            m_position_reg <= ld_pos;
            m_data_reg     <= ld_data;
            m_last_reg     <= ld_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_position = m_position_reg;
    assign m_data     = m_data_reg;
    assign m_last     = m_last_reg;

endmodule

@@ sv/dws_checker.sv @@
module dws_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [dws_pkg::FUNC_W-1:0]         s_func,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [dws_pkg::STATUS_W-1:0]       m_status,
    input logic [dws_pkg::POS_W-1:0]          m_position,
    input logic signed [dws_pkg::VALUE_W-1:0] m_data,
    input logic                               m_last
);
    import dws_pkg::*;

    // A new request is never taken while a result beat is stalled.
    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while a result beat is stalled");

    // Pushes and pops answer with a single final beat in the next cycle.
    a_single_beat_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FN_PUSH_FRONT || s_func == FN_PUSH_BACK ||
         s_func == FN_POP_FRONT || s_func == FN_POP_BACK))
        |=> (m_valid && m_last && m_data == '0 && m_position == '0))
        else $error("push or pop did not give one final beat");

    // Any failure status ends the request with no data and no position.
    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_last && m_data == '0 && m_position == '0))
        else $error("error beat carries payload or is not final");

    // Beats before the last one only come from a read-out.
    a_mid_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status == ST_OK && m_position == '0 && !s_ready))
        else $error("non-final beat outside a read-out");

endmodule

bind deque_with_search dws_checker u_dws_checker (.*);
